@@ rtl/fdtd_1d_yee_mur_step_defines.svh @@
// Assertion macros used by the RTL that checks itself.
`ifndef FDTD_1D_YEE_MUR_STEP_DEFINES_SVH
`define FDTD_1D_YEE_MUR_STEP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FDTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FDTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fdtd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_pkg
// Types, widths and fixed-point helpers for the 1D FDTD step engine.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int FRAC_BITS = 24;
  localparam int CELL_W    = 10;
  localparam int NCELL_W   = 11;
  localparam int F_W       = 40;
  localparam int CF_W      = 32;
  localparam int HALF_W    = CF_W / 2;
  localparam int SRC_W     = 26;
  localparam int K_W       = 26;
  localparam int D_W       = F_W + 1;
  localparam int PP_W      = D_W + HALF_W;
  localparam int PROD_W    = D_W + CF_W;
  localparam int Q_W       = PROD_W - FRAC_BITS;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic signed [F_W-1:0] F_MAX = {1'b0, {(F_W-1){1'b1}}};
  localparam logic signed [F_W-1:0] F_MIN = {1'b1, {(F_W-1){1'b0}}};
  localparam logic [Q_W-1:0] Q_POS_LIM = {{(Q_W-F_W+1){1'b0}}, {(F_W-1){1'b1}}};
  localparam logic [Q_W:0]   Q_NEG_LIM = (Q_W+1)'(1) << (F_W-1);

  localparam logic [NCELL_W-1:0] CELLS_RST  = NCELL_W'(1024);
  localparam logic [CELL_W-1:0]  SRCCELL_RST = CELL_W'(512);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_CELLS  = 2'd0,
    REG_SRC    = 2'd1,
    REG_BCOEF  = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_HSWEEP,
    ST_HDRAIN,
    ST_ESWEEP,
    ST_EDRAIN,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_MDRAIN
  } st_e;

  typedef struct packed {
    logic                    valid;
    logic [CF_W-1:0]         cmag;
    logic                    cneg;
    logic signed [D_W-1:0]   d;
    logic signed [F_W-1:0]   acc;
    logic                    to_h;
    logic [ADDR_W-1:0]       addr;
    logic                    add_src;
  } mac_req_t;

  typedef struct packed {
    logic                    valid;
    logic                    to_h;
    logic [ADDR_W-1:0]       addr;
    logic signed [F_W-1:0]   data;
  } wb_t;

  function automatic logic signed [F_W-1:0] sat_add(input logic signed [F_W-1:0] a,
                                                    input logic signed [F_W-1:0] b);
    logic signed [F_W:0] s;
    s = {a[F_W-1], a} + {b[F_W-1], b};
    if (s[F_W] != s[F_W-1]) begin
      return s[F_W] ? F_MIN : F_MAX;
    end
    return s[F_W-1:0];
  endfunction

  function automatic logic signed [D_W-1:0] diff(input logic signed [F_W-1:0] a,
                                                 input logic signed [F_W-1:0] b);
    return {a[F_W-1], a} - {b[F_W-1], b};
  endfunction

  function automatic logic signed [F_W-1:0] sext_src(input logic signed [SRC_W-1:0] v);
    return {{(F_W-SRC_W){v[SRC_W-1]}}, v};
  endfunction

endpackage

@@ rtl/fdtd_1d_yee_mur_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_1d_yee_mur_step
// 1D Yee FDTD engine with per-cell coefficients and first-order Mur edges.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; req_type_i selects
// load coefficients, time step, read E cell or clear fields.
// Load: coefficients written to the coefficient memory; busy stays low.
// Read: the E value appears on efield_value_o with efield_valid_o high for
//   one cycle, the cycle right after the transfer; the receiver cannot stall.
// Step: busy for a pass over the H memory and a pass over the E memory,
//   each followed by a drain of the 4-stage multiply-add, then edge reads
//   and Mur updates in states M0 to M6 and a final drain; with fewer than
//   three cells in use a step does nothing.
// Clear: zeroes the E and H memories, one E and H entry per cycle.
// The step's length is set by the single read port of each field memory.
// After reset the block runs the same clearing pass with busy high;
// registers come up at N = 1024, source cell 512, Mur coefficient zero.
// Configuration over the APB port is taken in any cycle, but change it only
// while the block is idle.
// ----------------------------------------------------------------------------
`include "fdtd_1d_yee_mur_step_defines.svh"

module fdtd_1d_yee_mur_step import fdtd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type_i,
  input  logic [CELL_W-1:0]        cell_index_i,
  input  logic [CF_W-1:0]          e_coef_i,
  input  logic [CF_W-1:0]          h_coef_i,
  input  logic signed [SRC_W-1:0]  source_sample_i,
  output logic                     efield_valid_o,
  output logic signed [F_W-1:0]    efield_value_o
);

  st_e state_q, state_d;

  logic [NCELL_W-1:0]    cells_q;
  logic [CELL_W-1:0]     srccell_q;
  logic signed [K_W-1:0] bcoef_q;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [ADDR_W-1:0]     s_q, s_d;
  logic signed [SRC_W-1:0] src_q;
  logic                  rd_oob_q;

  logic                  sv_q, sph_q;
  logic [ADDR_W-1:0]     kk_q;
  logic signed [F_W-1:0] prev_q;

  logic signed [F_W-1:0] e0_q, e1_q, en2_q, en1_q;
  logic signed [F_W-1:0] lprev_q, rprev_q;
  logic signed [F_W-1:0] e0s, en1s;

  logic                  accept, rd_accept, cfg_wr;
  req_e                  req;

  logic [ADDR_W-1:0]     e_raddr, h_raddr, c_raddr, e_waddr, h_waddr;
  logic                  e_we, h_we, c_we;
  logic [F_W-1:0]        e_wdata, h_wdata, e_rdata_u, h_rdata_u;
  logic signed [F_W-1:0] e_rdata, h_rdata;
  logic [2*CF_W-1:0]     c_rdata;

  mac_req_t              mac_req;
  wb_t                   wb;
  logic                  mac_busy;
  logic [K_W-1:0]        kmag;

  assign req       = req_e'(req_type_i);
  assign accept    = start && !busy;
  assign rd_accept = accept && (req == REQ_READ);
  assign busy      = (state_q != ST_IDLE);
  assign e_rdata   = e_rdata_u;
  assign h_rdata   = h_rdata_u;
  assign kmag      = bcoef_q[K_W-1] ? K_W'(-bcoef_q) : K_W'(bcoef_q);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_CELLS: prdata = PDATA_W'(cells_q);
      REG_SRC:   prdata = PDATA_W'(srccell_q);
      REG_BCOEF: prdata = {{(PDATA_W-K_W){bcoef_q[K_W-1]}}, bcoef_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q   <= CELLS_RST;
      srccell_q <= SRCCELL_RST;
      bcoef_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_CELLS: cells_q   <= pwdata[NCELL_W-1:0];
        REG_SRC:   srccell_q <= pwdata[CELL_W-1:0];
        REG_BCOEF: bcoef_q   <= pwdata[K_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // step geometry
  always_comb begin
    n_d = (int'(cells_q) > MAX_CELLS) ? CNT_W'(MAX_CELLS) : CNT_W'(cells_q);
    s_d = (int'(srccell_q) >= int'(n_d)) ? ADDR_W'(n_d >> 1) : ADDR_W'(srccell_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CNT_W'(MAX_CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_STEP:  state_d = (int'(cells_q) < 3) ? ST_IDLE : ST_HSWEEP;
            REQ_READ:  state_d = ST_READ;
            REQ_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_d = ST_IDLE;
      ST_HSWEEP: begin
        if (cnt_q == n_q - CNT_W'(1)) state_d = ST_HDRAIN;
      end
      ST_HDRAIN: begin
        if (!sv_q && !mac_busy) state_d = ST_ESWEEP;
      end
      ST_ESWEEP: begin
        if (cnt_q == n_q - CNT_W'(2)) state_d = ST_EDRAIN;
      end
      ST_EDRAIN: begin
        if (!sv_q && !mac_busy) state_d = ST_M0;
      end
      ST_M0:     state_d = ST_M1;
      ST_M1:     state_d = ST_M2;
      ST_M2:     state_d = ST_M3;
      ST_M3:     state_d = ST_M4;
      ST_M4:     state_d = ST_M5;
      ST_M5:     state_d = ST_M6;
      ST_M6:     state_d = ST_MDRAIN;
      ST_MDRAIN: begin
        if (!mac_busy) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    case (state_q)
      ST_CLEAR, ST_HSWEEP, ST_ESWEEP: cnt_d = cnt_q + CNT_W'(1);
      default: cnt_d = '0;
    endcase
    if (state_d != state_q) cnt_d = '0;
  end

  // edge values with the source folded in where it lands on an edge
  always_comb begin
    e0s  = (s_q == '0) ? sat_add(e0_q, sext_src(src_q)) : e0_q;
    en1s = (s_q == ADDR_W'(n_q - CNT_W'(1))) ? sat_add(en1_q, sext_src(src_q)) : en1_q;
  end

  // outputs: memory addresses and multiply-add requests
  always_comb begin
    e_raddr = ADDR_W'(cell_index_i);
    h_raddr = ADDR_W'(cnt_q);
    c_raddr = ADDR_W'(cnt_q);
    mac_req = '0;
    case (state_q)
      ST_HSWEEP: begin
        e_raddr = ADDR_W'(cnt_q);
        h_raddr = ADDR_W'(cnt_q) - ADDR_W'(1);
        c_raddr = ADDR_W'(cnt_q) - ADDR_W'(1);
      end
      ST_ESWEEP: begin
        e_raddr = ADDR_W'(cnt_q);
      end
      ST_M0: e_raddr = '0;
      ST_M1: e_raddr = ADDR_W'(1);
      ST_M2: e_raddr = ADDR_W'(n_q - CNT_W'(2));
      ST_M3: e_raddr = ADDR_W'(n_q - CNT_W'(1));
      ST_M5: begin
        mac_req.valid = 1'b1;
        mac_req.cmag  = CF_W'(kmag);
        mac_req.cneg  = bcoef_q[K_W-1];
        mac_req.d     = diff(e1_q, e0s);
        mac_req.acc   = lprev_q;
        mac_req.addr  = '0;
      end
      ST_M6: begin
        mac_req.valid = 1'b1;
        mac_req.cmag  = CF_W'(kmag);
        mac_req.cneg  = bcoef_q[K_W-1];
        mac_req.d     = diff(en2_q, en1s);
        mac_req.acc   = rprev_q;
        mac_req.addr  = ADDR_W'(n_q - CNT_W'(1));
      end
      default: begin
      end
    endcase
    if (sv_q && (kk_q != '0)) begin
      mac_req.valid = 1'b1;
      mac_req.cneg  = 1'b0;
      if (sph_q) begin
        mac_req.cmag = c_rdata[CF_W-1:0];
        mac_req.d    = diff(e_rdata, prev_q);
        mac_req.acc  = h_rdata;
        mac_req.to_h = 1'b1;
        mac_req.addr = kk_q - ADDR_W'(1);
      end else begin
        mac_req.cmag    = c_rdata[2*CF_W-1:CF_W];
        mac_req.d       = diff(h_rdata, prev_q);
        mac_req.acc     = e_rdata;
        mac_req.addr    = kk_q;
        mac_req.add_src = (kk_q == s_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      sv_q    <= 1'b0;
      lprev_q <= '0;
      rprev_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sv_q    <= (state_q == ST_HSWEEP) || (state_q == ST_ESWEEP);
      if (state_q == ST_CLEAR) begin
        lprev_q <= '0;
        rprev_q <= '0;
      end
      if (state_q == ST_M5) lprev_q <= e1_q;
      if (state_q == ST_M6) rprev_q <= en2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sph_q  <= (state_q == ST_HSWEEP);
    kk_q   <= ADDR_W'(cnt_q);
    prev_q <= sph_q ? e_rdata : h_rdata;
    if (accept) begin
      n_q      <= n_d;
      s_q      <= s_d;
      src_q    <= source_sample_i;
      rd_oob_q <= (int'(cell_index_i) >= MAX_CELLS);
    end
    if (state_q == ST_M1) e0_q  <= e_rdata;
    if (state_q == ST_M2) e1_q  <= e_rdata;
    if (state_q == ST_M3) en2_q <= e_rdata;
    if (state_q == ST_M4) en1_q <= e_rdata;
  end

  // memory write ports
  always_comb begin
    c_we    = accept && (req == REQ_LOAD) && (int'(cell_index_i) < MAX_CELLS);
    e_we    = wb.valid && !wb.to_h;
    h_we    = wb.valid && wb.to_h;
    e_waddr = wb.addr;
    h_waddr = wb.addr;
    e_wdata = wb.data;
    h_wdata = wb.data;
    if (state_q == ST_CLEAR) begin
      e_we    = 1'b1;
      h_we    = 1'b1;
      e_waddr = ADDR_W'(cnt_q);
      h_waddr = ADDR_W'(cnt_q);
      e_wdata = '0;
      h_wdata = '0;
    end
  end

  fdtd_ram #(.WIDTH(F_W), .DEPTH(MAX_CELLS)) u_e_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata_u)
  );

  fdtd_ram #(.WIDTH(F_W), .DEPTH(MAX_CELLS)) u_h_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata_u)
  );

  fdtd_ram #(.WIDTH(2*CF_W), .DEPTH(MAX_CELLS)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (ADDR_W'(cell_index_i)),
    .wdata_i ({e_coef_i, h_coef_i}),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  fdtd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .src_i  (src_q),
    .wb_o   (wb),
    .busy_o (mac_busy)
  );

  assign efield_valid_o = (state_q == ST_READ);
  assign efield_value_o = rd_oob_q ? '0 : e_rdata;

  `FDTD_ASSERT_NOW(a_result_after_read, efield_valid_o, $past(rd_accept), "result without read")
  `FDTD_ASSERT_NOW(a_idle_no_mac, !busy, !mac_busy, "idle with update in flight")
  `FDTD_ASSERT_NEXT(a_read_gives_result, rd_accept, efield_valid_o, "read gave no result")

endmodule

@@ rtl/fdtd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fdtd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fdtd_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_mac
// Four-stage field update: acc + floor(c*d / 2^FRAC_BITS), saturated,
// plus optional source sample, routed back to the E or H memory.
// ----------------------------------------------------------------------------
module fdtd_mac import fdtd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_req_t                req_i,
  input  logic signed [SRC_W-1:0] src_i,
  output wb_t                     wb_o,
  output logic                    busy_o
);

  mac_req_t req_q;

  logic                  s2_valid_q, s2_neg_q, s2_to_h_q, s2_add_q;
  logic [ADDR_W-1:0]     s2_addr_q;
  logic signed [F_W-1:0] s2_acc_q;
  logic [PP_W-1:0]       s2_pl_q, s2_ph_q;

  logic                  s3_valid_q, s3_to_h_q, s3_add_q;
  logic [ADDR_W-1:0]     s3_addr_q;
  logic signed [F_W-1:0] s3_acc_q, s3_prod_q;

  wb_t wb_q;

  logic [D_W-1:0]        mag;
  logic [PROD_W-1:0]     prod;
  logic [Q_W-1:0]        quo;
  logic                  rem;
  logic [Q_W:0]          quo_r;
  logic signed [F_W-1:0] prod_d;
  logic signed [F_W-1:0] sum1, sum2;

  always_comb begin
    mag = req_q.d[D_W-1] ? D_W'(-req_q.d) : D_W'(req_q.d);
  end

  always_comb begin
    prod  = {{HALF_W{1'b0}}, s2_pl_q} + {s2_ph_q, {HALF_W{1'b0}}};
    quo   = prod[PROD_W-1:FRAC_BITS];
    rem   = |prod[FRAC_BITS-1:0];
    quo_r = {1'b0, quo} + {{Q_W{1'b0}}, rem};
    if (!s2_neg_q) begin
      prod_d = (quo > Q_POS_LIM) ? F_MAX : F_W'(quo);
    end else begin
      prod_d = (quo_r > Q_NEG_LIM) ? F_MIN : -F_W'(quo_r);
    end
  end

  always_comb begin
    sum1 = sat_add(s3_acc_q, s3_prod_q);
    sum2 = s3_add_q ? sat_add(sum1, sext_src(src_i)) : sum1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q      <= '0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      wb_q       <= '0;
    end else begin
      req_q      <= req_i;
      s2_valid_q <= req_q.valid;
      s3_valid_q <= s2_valid_q;
      wb_q.valid <= s3_valid_q;
      wb_q.data  <= sum2;
      wb_q.to_h  <= s3_to_h_q;
      wb_q.addr  <= s3_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_pl_q   <= {{HALF_W{1'b0}}, mag} * {{D_W{1'b0}}, req_q.cmag[HALF_W-1:0]};
    s2_ph_q   <= {{HALF_W{1'b0}}, mag} * {{D_W{1'b0}}, req_q.cmag[CF_W-1:HALF_W]};
    s2_neg_q  <= req_q.cneg ^ req_q.d[D_W-1];
    s2_acc_q  <= req_q.acc;
    s2_to_h_q <= req_q.to_h;
    s2_addr_q <= req_q.addr;
    s2_add_q  <= req_q.add_src;

    s3_prod_q <= prod_d;
    s3_acc_q  <= s2_acc_q;
    s3_to_h_q <= s2_to_h_q;
    s3_addr_q <= s2_addr_q;
    s3_add_q  <= s2_add_q;
  end

  assign wb_o   = wb_q;
  assign busy_o = req_q.valid | s2_valid_q | s3_valid_q | wb_q.valid;

endmodule
